### rtl/ordered_value_list_macros.svh
// ----------------------------------------------------------------------------
// Ordered value list assertion macros
// Concurrent checks that compile to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define OVL_ASSERT_SAME(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ordered_value_list: same-cycle check failed");
// next-cycle implication
`define OVL_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ordered_value_list: next-cycle check failed");
`else
`define OVL_ASSERT_SAME(name, pre, post)
`define OVL_ASSERT_NEXT(name, pre, post)
`endif

`endif

### rtl/ovl_pkg.sv
// ----------------------------------------------------------------------------
// Ordered value list package
// Command and status codes, and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ovl_pkg;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_SEARCH = 3'd1;
   localparam logic [2:0] ACT_MODIFY = 3'd2;
   localparam logic [2:0] ACT_DELETE = 3'd3;
   localparam logic [2:0] ACT_DUMP   = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   // most results one dump may give
   localparam int MAX_RESULTS = 16;

   typedef struct packed {
      logic       load;
      logic       idx_clr;
      logic       idx_from_match;
      logic       rd_issue;
      logic       wr_insert;
      logic       wr_modify;
      logic       wr_shift;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       pend_load;
      logic [1:0] pend_status;
      logic       pend_match;
      logic       out_pend;
      logic       out_dump;
   } ovl_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       empty;
      logic       full;
      logic       can_issue;
      logic       dump_more;
      logic       rd_vld;
      logic       match;
      logic       pend_ok;
      logic       out_free;
   } ovl_stat_type;

endpackage

### rtl/ovl_datapath.sv
// ----------------------------------------------------------------------------
// Ordered value list datapath
// Entry memory, fill count, walk index, pending result and output register.
// ----------------------------------------------------------------------------
module ovl_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ovl_pkg::ovl_cmd_type cmd,
   output ovl_pkg::ovl_stat_type stat,
   input  logic [2:0]           req_action,
   input  logic signed [31:0]   req_key_value,
   input  logic signed [31:0]   req_replacement,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_element,
   output logic [3:0]           rsp_position,
   output logic                 rsp_last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DumpLim = (CAPACITY < ovl_pkg::MAX_RESULTS) ? CAPACITY
                                                               : ovl_pkg::MAX_RESULTS;

   logic signed [31:0] mem [CAPACITY];

   logic [2:0]         action_ff;
   logic signed [31:0] key_ff;
   logic signed [31:0] repl_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic signed [31:0] rd_data_ff;
   logic [AW-1:0]      rd_pos_ff;
   logic               rd_vld_ff;
   logic [1:0]         pend_status_ff;
   logic signed [31:0] pend_element_ff;
   logic [3:0]         pend_pos_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic signed [31:0] rsp_element_ff;
   logic [3:0]         rsp_position_ff;
   logic               rsp_last_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               out_free;
   logic               dump_more;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dump_more = (idx_ff < count_ff) && (idx_ff < CW'(DumpLim));

   always_comb begin
      stat           = '0;
      stat.action    = action_ff;
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.can_issue = (idx_ff < count_ff);
      stat.dump_more = dump_more;
      stat.rd_vld    = rd_vld_ff;
      stat.match     = rd_vld_ff && (rd_data_ff == key_ff);
      stat.pend_ok   = (pend_status_ff == ovl_pkg::STAT_OK);
      stat.out_free  = out_free;
   end

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_pos_ff;
      wr_data = rd_data_ff;
      if (cmd.wr_insert) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = key_ff;
      end else if (cmd.wr_modify) begin
         wr_en   = 1'b1;
         wr_addr = rd_pos_ff;
         wr_data = repl_ff;
      end else if (cmd.wr_shift) begin
         // move the entry just read one place toward the head
         wr_en   = 1'b1;
         wr_addr = rd_pos_ff - AW'(1);
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
         rd_pos_ff  <= idx_ff[AW-1:0];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_from_match) begin
         idx_in = CW'(rd_pos_ff) + CW'(1);
      end else if (cmd.rd_issue) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_pend || cmd.out_dump) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_vld_ff    <= cmd.rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         action_ff <= req_action;
         key_ff    <= req_key_value;
         repl_ff   <= req_replacement;
      end
      if (cmd.pend_load) begin
         pend_status_ff  <= cmd.pend_status;
         pend_element_ff <= cmd.pend_match ? rd_data_ff : 32'sd0;
         pend_pos_ff     <= cmd.pend_match ? 4'(rd_pos_ff) : 4'd0;
      end
      if (cmd.out_pend) begin
         rsp_status_ff   <= pend_status_ff;
         rsp_element_ff  <= pend_element_ff;
         rsp_position_ff <= pend_pos_ff;
         rsp_last_ff     <= 1'b1;
      end else if (cmd.out_dump) begin
         rsp_status_ff   <= ovl_pkg::STAT_OK;
         rsp_element_ff  <= rd_data_ff;
         rsp_position_ff <= 4'(rd_pos_ff);
         rsp_last_ff     <= !dump_more;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### rtl/ovl_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered value list controller
// Sequences each command over the datapath: decode, scan, shift, dump, emit.
// ----------------------------------------------------------------------------
module ovl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ovl_pkg::ovl_stat_type stat,
   output ovl_pkg::ovl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DECODE   = 7'b0000010,
      ST_SCAN     = 7'b0000100,
      ST_EMIT     = 7'b0001000,
      ST_SHIFT    = 7'b0010000,
      ST_DUMP_RD  = 7'b0100000,
      ST_DUMP_OUT = 7'b1000000
   } ovl_state_type;

   ovl_state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.action) inside
               ovl_pkg::ACT_INSERT: begin
                  cmd.pend_load = 1'b1;
                  if (stat.full) begin
                     cmd.pend_status = ovl_pkg::STAT_FULL;
                  end else begin
                     cmd.wr_insert   = 1'b1;
                     cmd.cnt_inc     = 1'b1;
                     cmd.pend_status = ovl_pkg::STAT_OK;
                  end
                  state_in = ST_EMIT;
               end
               ovl_pkg::ACT_SEARCH, ovl_pkg::ACT_MODIFY, ovl_pkg::ACT_DELETE: begin
                  if (stat.empty) begin
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = ovl_pkg::STAT_EMPTY;
                     state_in        = ST_EMIT;
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = ST_SCAN;
                  end
               end
               ovl_pkg::ACT_DUMP: begin
                  if (stat.empty) begin
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = ovl_pkg::STAT_EMPTY;
                     state_in        = ST_EMIT;
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = ST_DUMP_RD;
                  end
               end
               default: begin
                  // drop unknown commands without a result
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.match) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = ovl_pkg::STAT_OK;
               cmd.pend_match  = 1'b1;
               if (stat.action == ovl_pkg::ACT_MODIFY) begin
                  cmd.wr_modify = 1'b1;
               end
               if (stat.action == ovl_pkg::ACT_DELETE) begin
                  cmd.idx_from_match = 1'b1;
               end
               state_in = ST_EMIT;
            end else if (stat.can_issue) begin
               cmd.rd_issue = 1'b1;
            end else if (!stat.rd_vld) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = ovl_pkg::STAT_NOTFOUND;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_pend = 1'b1;
               if (stat.action == ovl_pkg::ACT_DELETE && stat.pend_ok) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SHIFT: begin
            if (stat.rd_vld) begin
               cmd.wr_shift = 1'b1;
            end
            if (stat.can_issue) begin
               cmd.rd_issue = 1'b1;
            end else if (!stat.rd_vld) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            // hold the read entry until the output slot frees up
            if (stat.out_free) begin
               cmd.out_dump = 1'b1;
               if (stat.dump_more) begin
                  cmd.rd_issue = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/ordered_value_list.sv
// ----------------------------------------------------------------------------
// Ordered value list
// Bounded list of signed 32-bit values kept in insertion order.
// ----------------------------------------------------------------------------
// Use: the req_ channel takes one command transaction (action, key_value,
// replacement) when req_valid is high and req_stall is low. Insert, search,
// modify and delete give one rsp_ transaction; dump gives one per element
// from the head (at most 16), with rsp_last on the final one.
// Insert, and any command on an empty list, go from decode straight to the
// result. Search, modify and delete walk the entry memory one entry a cycle
// from the head, stopping at the first match or after the last entry.
// Delete then closes the gap, moving each later entry one place toward the
// head. Dump gives one transaction a cycle while the receiver does not
// stall. A new command is taken once the previous one is done.
// Reset empties the list; the entry memory is not cleared.
// When the receiver stalls, the output register holds its transaction and
// the next result waits; no result is lost or repeated.
// ----------------------------------------------------------------------------
module ordered_value_list #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_key_value,
   input  logic signed [31:0] req_replacement,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic [3:0]         rsp_position,
   output logic               rsp_last
);

`include "ordered_value_list_macros.svh"

   ovl_pkg::ovl_cmd_type  cmd;
   ovl_pkg::ovl_stat_type stat;

   ovl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ovl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_key_value   (req_key_value),
      .req_replacement (req_replacement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_position    (rsp_position),
      .rsp_last        (rsp_last)
   );

   `OVL_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `OVL_ASSERT_SAME(a_push_needs_slot, cmd.out_pend || cmd.out_dump, stat.out_free)
   `OVL_ASSERT_SAME(a_one_writer, 1'b1, $onehot0({cmd.wr_insert, cmd.wr_modify, cmd.wr_shift}))
   `OVL_ASSERT_NEXT(a_rsp_after_push, cmd.out_pend || cmd.out_dump, rsp_valid)

endmodule

### tb/ordered_value_list_test.sv
// ----------------------------------------------------------------------------
// Ordered value list testbench
// A table of directed commands, then random command sequences run under
// four idling phases. Every response transaction is checked against a
// behavioral copy of the list, or against a result typed into the table.
// ----------------------------------------------------------------------------
module ordered_value_list_test;

   localparam int CAPACITY       = 16;
   localparam int ITEMS_PER_PHASE = 104;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int MAX_REPORTS    = 10;

   // actions the block ignores
   localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
   localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

   localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'h7fff_ffff;

   localparam int SEND_IDLE_PCT [4] = '{0, 62, 0, 11};
   localparam int RSP_STALL_PCT [4] = '{0, 0, 62, 11};

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [3:0]         position;
      logic               last;
   } list_rsp_type;

   typedef struct packed {
      logic [2:0]         act;
      logic signed [31:0] key;
      logic signed [31:0] repl;
      logic [4:0]         reps;
      logic               typed;
      logic               typed_n;
      list_rsp_type       rsp;
   } dir_row_type;

   localparam list_rsp_type NO_RSP = '{ovl_pkg::STAT_OK, 32'sd0, 4'd0, 1'b0};
   localparam list_rsp_type RSP_EMPTY = '{ovl_pkg::STAT_EMPTY, 32'sd0, 4'd0, 1'b1};
   localparam list_rsp_type RSP_DONE = '{ovl_pkg::STAT_OK, 32'sd0, 4'd0, 1'b1};

   localparam int NUM_ROWS = 24;
   localparam dir_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ovl_pkg::ACT_SEARCH, 32'sd5, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_EMPTY},
      '{ovl_pkg::ACT_MODIFY, 32'sd5, VAL_MIN, 5'd1, 1'b1, 1'b1, RSP_EMPTY},
      '{ovl_pkg::ACT_DELETE, 32'sd5, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_EMPTY},
      '{ovl_pkg::ACT_DUMP, 32'sd0, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_EMPTY},
      '{ACT_RESERVED_HI, VAL_MAX, VAL_MAX, 5'd1, 1'b1, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_INSERT, VAL_MIN, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_DONE},
      // deleting the only element must leave an empty list behind
      '{ovl_pkg::ACT_DELETE, VAL_MIN, 32'sd0, 5'd1, 1'b1, 1'b1,
        '{ovl_pkg::STAT_OK, VAL_MIN, 4'd0, 1'b1}},
      '{ovl_pkg::ACT_DUMP, 32'sd0, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_EMPTY},
      '{ovl_pkg::ACT_INSERT, VAL_MAX, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_DONE},
      '{ovl_pkg::ACT_INSERT, -32'sd1, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_DONE},
      '{ovl_pkg::ACT_SEARCH, -32'sd1, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_SEARCH, 32'sd12345, 32'sd0, 5'd1, 1'b1, 1'b1,
        '{ovl_pkg::STAT_NOTFOUND, 32'sd0, 4'd0, 1'b1}},
      '{ovl_pkg::ACT_MODIFY, VAL_MAX, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_SEARCH, 32'sd0, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_INSERT, 32'sd5, 32'sd0, 5'd13, 1'b1, 1'b1, RSP_DONE},
      '{ovl_pkg::ACT_INSERT, 32'sd777, 32'sd0, 5'd1, 1'b1, 1'b1, RSP_DONE},
      '{ovl_pkg::ACT_INSERT, 32'sd1, 32'sd0, 5'd1, 1'b1, 1'b1,
        '{ovl_pkg::STAT_FULL, 32'sd0, 4'd0, 1'b1}},
      '{ovl_pkg::ACT_DUMP, 32'sd0, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_SEARCH, 32'sd777, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_MODIFY, 32'sd5, VAL_MAX, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_DELETE, 32'sd777, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_DELETE, 32'sd0, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP},
      '{ACT_RESERVED_LO, 32'sd5, 32'sd5, 5'd1, 1'b1, 1'b0, NO_RSP},
      '{ovl_pkg::ACT_DUMP, 32'sd0, 32'sd0, 5'd1, 1'b0, 1'b0, NO_RSP}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_action;
   logic signed [31:0] req_key_value;
   logic signed [31:0] req_replacement;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_element;
   logic [3:0]         rsp_position;
   logic               rsp_last;

   // behavioral copy of the list
   logic signed [31:0] list_vals [CAPACITY];
   int                 list_len;
   list_rsp_type       step_rsps [$];
   list_rsp_type       pending_rsps [$];

   // typed result of the transaction on offer
   bit                 cur_typed;
   bit                 cur_typed_n;
   list_rsp_type       cur_typed_rsp;

   int                 send_idle_pct;
   int                 rsp_stall_pct;
   bit                 rsp_hold_request;
   int                 mismatches;
   int                 idle_cycles;
   list_rsp_type       got;
   list_rsp_type       want;

   ordered_value_list #(.CAPACITY(CAPACITY)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key_value   (req_key_value),
      .req_replacement (req_replacement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_position    (rsp_position),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic list_rsp_type make_rsp(logic [1:0] status,
                                             logic signed [31:0] element,
                                             logic [3:0] position, logic last);
      list_rsp_type r;
      r.status   = status;
      r.element  = element;
      r.position = position;
      r.last     = last;
      return r;
   endfunction

   // apply one command to the list copy and collect the responses it causes
   task automatic list_apply(input logic [2:0] act, input logic signed [31:0] key,
                             input logic signed [31:0] repl);
      int hit;
      int n;
      hit = -1;
      step_rsps.delete();
      case (act)
         ovl_pkg::ACT_INSERT: begin
            if (list_len >= CAPACITY) begin
               step_rsps.push_back(make_rsp(ovl_pkg::STAT_FULL, 32'sd0, 4'd0, 1'b1));
            end else begin
               list_vals[list_len] = key;
               list_len++;
               step_rsps.push_back(make_rsp(ovl_pkg::STAT_OK, 32'sd0, 4'd0, 1'b1));
            end
         end
         ovl_pkg::ACT_SEARCH, ovl_pkg::ACT_MODIFY, ovl_pkg::ACT_DELETE: begin
            if (list_len == 0) begin
               step_rsps.push_back(make_rsp(ovl_pkg::STAT_EMPTY, 32'sd0, 4'd0, 1'b1));
            end else begin
               for (int i = 0; i < list_len; i++)
                  if (hit < 0 && list_vals[i] == key) hit = i;
               if (hit < 0) begin
                  step_rsps.push_back(make_rsp(ovl_pkg::STAT_NOTFOUND, 32'sd0, 4'd0, 1'b1));
               end else begin
                  step_rsps.push_back(make_rsp(ovl_pkg::STAT_OK, list_vals[hit], 4'(hit),
                                               1'b1));
                  if (act == ovl_pkg::ACT_MODIFY) begin
                     list_vals[hit] = repl;
                  end else if (act == ovl_pkg::ACT_DELETE) begin
                     // close the gap, keep the order
                     for (int i = hit; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
                     list_len--;
                  end
               end
            end
         end
         ovl_pkg::ACT_DUMP: begin
            if (list_len == 0) begin
               step_rsps.push_back(make_rsp(ovl_pkg::STAT_EMPTY, 32'sd0, 4'd0, 1'b1));
            end else begin
               n = (list_len < ovl_pkg::MAX_RESULTS) ? list_len : ovl_pkg::MAX_RESULTS;
               for (int i = 0; i < n; i++)
                  step_rsps.push_back(make_rsp(ovl_pkg::STAT_OK, list_vals[i], 4'(i),
                                               i == n - 1));
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(7))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2, 3: return int'($urandom_range(8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // called and returns at a falling edge; valid stays high after acceptance
   task automatic send_item(input logic [2:0] act, input logic signed [31:0] key,
                            input logic signed [31:0] repl, input bit typed = 1'b0,
                            input bit typed_n = 1'b0,
                            input list_rsp_type typed_rsp = NO_RSP);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_key_value   <= key;
      req_replacement <= repl;
      cur_typed       = typed;
      cur_typed_n     = typed_n;
      cur_typed_rsp   = typed_rsp;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_key();
      if (list_len > 0 && $urandom_range(99) < 75) return list_vals[$urandom_range(list_len - 1)];
      return pick_value();
   endfunction

   task automatic run_random(input int count);
      int sent;
      int pick;
      int k;
      logic [2:0] act;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            // fill, sometimes past full
            k = (pick < 8) ? CAPACITY - list_len + $urandom_range(2) : $urandom_range(1, 8);
            repeat (k) begin
               send_item(ovl_pkg::ACT_INSERT, pick_value(), pick_value());
               sent++;
            end
         end else if (pick < 60) begin
            repeat ($urandom_range(1, 6)) begin
               act = 3'($urandom_range(ovl_pkg::ACT_SEARCH, ovl_pkg::ACT_DELETE));
               send_item(act, pick_key(), pick_value());
               sent++;
            end
         end else if (pick < 75) begin
            send_item(ovl_pkg::ACT_DUMP, pick_value(), pick_value());
            sent++;
         end else if (pick < 88) begin
            // drain toward empty
            k = list_len + $urandom_range(1);
            repeat (k) begin
               send_item(ovl_pkg::ACT_DELETE, pick_key(), pick_value());
               sent++;
            end
         end else begin
            act = 3'($urandom_range(7));
            send_item(act, $urandom, $urandom);
            if (act <= ovl_pkg::ACT_DUMP) sent++;
         end
      end
   endtask

   // request prediction and response checking
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            list_apply(req_action, req_key_value, req_replacement);
            if (cur_typed) begin
               if (cur_typed_n) pending_rsps.push_back(cur_typed_rsp);
            end else begin
               foreach (step_rsps[i]) pending_rsps.push_back(step_rsps[i]);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = make_rsp(rsp_status, rsp_element, rsp_position, rsp_last);
            if (pending_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response: status %0d element %0d position %0d last %0d",
                           got.status, $signed(got.element), got.position, got.last);
            end else begin
               want = pending_rsps.pop_front();
               if (got.status !== want.status || got.element !== want.element ||
                   got.position !== want.position || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              want.status, $signed(want.element), want.position, want.last,
                              got.status, $signed(got.element), got.position, got.last);
               end
            end
         end
      end
   end

   // receiver: random stalls, or one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("ordered_value_list_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ovl_pkg::ACT_INSERT;
      req_key_value    = 32'sd0;
      req_replacement  = 32'sd0;
      list_len         = 0;
      cur_typed        = 1'b0;
      cur_typed_n      = 1'b0;
      cur_typed_rsp    = NO_RSP;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      rsp_hold_request = 1'b0;
      mismatches       = 0;
      idle_cycles      = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++)
         repeat (DIRECTED_ROWS[r].reps)
            send_item(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].repl,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].typed_n, DIRECTED_ROWS[r].rsp);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE_PCT[p];
         rsp_stall_pct = RSP_STALL_PCT[p];
         // hold the receiver off while commands keep coming
         if (p == 2) rsp_hold_request = 1'b1;
         run_random(ITEMS_PER_PHASE);
      end
      req_valid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsps.size() != 0) mismatches += pending_rsps.size();

      if (mismatches == 0) begin
         $display("ordered_value_list_test OK");
      end else begin
         $display("ordered_value_list_test NOT OK");
      end
      $finish;
   end

endmodule
